/* hdl/fcf_pkg.sv */
// fcf_pkg: shared types and constants for the fir convolution filter unit
// request and result payload structs, tap and accumulator widths
// no dependencies
package fcf_pkg;

  localparam int MAX_TAPS    = 256;
  localparam int SAMPLE_BITS = 16;
  localparam int FRAC_BITS   = SAMPLE_BITS - 1;
  localparam int TAP_BITS    = $clog2(MAX_TAPS);
  localparam int TAPN_W      = TAP_BITS + 1;
  localparam int PROD_W      = 2 * SAMPLE_BITS;
  localparam int ACC_W       = PROD_W + TAP_BITS;

  localparam int COEF_INDEX_W = 8;
  localparam int TAP_COUNT_W  = 9;
  localparam int APB_DATA_W   = 32;
  localparam int APB_ADDR_W   = 3;

  // register indexes on the configuration port
  localparam int REG_TAP_COUNT = 0;

  localparam logic [TAP_COUNT_W-1:0] TAP_COUNT_RESET = TAP_COUNT_W'(1);

  typedef enum logic {
    REQ_LOAD   = 1'b0,
    REQ_SAMPLE = 1'b1
  } req_type_t;

  typedef struct packed {
    req_type_t                     req_type;
    logic [COEF_INDEX_W-1:0]       coef_index;
    logic signed [SAMPLE_BITS-1:0] coef_value;
    logic signed [SAMPLE_BITS-1:0] sample;
  } req_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] out_sample;
    logic                          saturated;
  } res_t;

endpackage

/* hdl/fir_convolution_filter_unit.sv */
// fir_convolution_filter_unit: direct-form fir with stored impulse response
// one shared 16x16 multiply-accumulate stepped over the taps by a small sequencer
// depends on fcf_pkg
//
//   channel   signals                        direction  moves
//   req       req_valid req_stall req_data   in         load coef or sample request
//   res       res_valid res_stall res_data   out        rounded, saturated sample
//   apb       psel penable pwrite paddr ...  in/out     tap_count register
//
// a load request does not leave the idle state; a sample request blocks new requests
// until its result enters the output register, stepping ntaps taps (ntaps is
// tap_count clamped to 1..256) through the single multiply-accumulate unit, one tap
// per cycle, with read, multiply, accumulate and done stages.
// reset clears tap_count to 1 and empties both stores (read back as zero)
// through per-entry coef valid bits and a delay-line fill count.
// a held result in the output register does not block new requests; a finished
// sum waits in the done state until the output register is free.
module fir_convolution_filter_unit (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           req_valid,
  output logic                           req_stall,
  input  fcf_pkg::req_t                  req_data,
  output logic                           res_valid,
  input  logic                           res_stall,
  output fcf_pkg::res_t                  res_data,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [fcf_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [fcf_pkg::APB_DATA_W-1:0] pwdata,
  output logic [fcf_pkg::APB_DATA_W-1:0] prdata,
  output logic                           pready
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_DONE
  } state_t;

  state_t state;

  logic [fcf_pkg::TAP_COUNT_W-1:0] tap_count;

  // coefficient store and its valid bits
  logic signed [fcf_pkg::SAMPLE_BITS-1:0] coef_mem [fcf_pkg::MAX_TAPS];
  logic [fcf_pkg::MAX_TAPS-1:0]           coef_valid;

  // delay line as a circular buffer, head holds the newest sample
  logic signed [fcf_pkg::SAMPLE_BITS-1:0] delay_mem [fcf_pkg::MAX_TAPS];
  logic [fcf_pkg::TAP_BITS-1:0]           head;
  logic [fcf_pkg::TAPN_W-1:0]             fill;

  logic [fcf_pkg::TAPN_W-1:0] ntaps;
  logic [fcf_pkg::TAPN_W-1:0] k;

  // read stage
  logic                                   s1_valid;
  logic signed [fcf_pkg::SAMPLE_BITS-1:0] d_rd;
  logic signed [fcf_pkg::SAMPLE_BITS-1:0] c_rd;
  logic                                   d_ok;
  logic                                   c_ok;

  // multiply stage
  logic                              s2_valid;
  logic signed [fcf_pkg::PROD_W-1:0] prod;

  logic signed [fcf_pkg::ACC_W-1:0] acc;

  logic req_accept;
  logic load_accept;
  logic sample_accept;
  logic cfg_write;
  logic issue;

  logic [fcf_pkg::TAP_BITS-1:0] coef_addr;
  logic [fcf_pkg::TAP_BITS-1:0] head_next;
  logic [fcf_pkg::TAP_BITS-1:0] rd_coef_addr;
  logic [fcf_pkg::TAP_BITS-1:0] rd_delay_addr;
  logic [fcf_pkg::TAPN_W-1:0]   ntaps_next;

  logic signed [fcf_pkg::SAMPLE_BITS-1:0] d_op;
  logic signed [fcf_pkg::SAMPLE_BITS-1:0] c_op;

  logic signed [fcf_pkg::ACC_W-1:0] rnd;
  logic signed [fcf_pkg::ACC_W-1:0] q;
  logic                             sat_hi;
  logic                             sat_lo;
  fcf_pkg::res_t                    res_next;

  assign req_stall     = (state != S_IDLE);
  assign req_accept    = req_valid && !req_stall;
  assign load_accept   = req_accept && (req_data.req_type == fcf_pkg::REQ_LOAD);
  assign sample_accept = req_accept && (req_data.req_type == fcf_pkg::REQ_SAMPLE);

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready
                     && (32'(paddr >> 2) == fcf_pkg::REG_TAP_COUNT);

  always_comb begin
    if (32'(paddr >> 2) == fcf_pkg::REG_TAP_COUNT) begin
      prdata = fcf_pkg::APB_DATA_W'(tap_count);
    end else begin
      prdata = '0;
    end
  end

  assign coef_addr = fcf_pkg::TAP_BITS'(req_data.coef_index);
  assign head_next = head + fcf_pkg::TAP_BITS'(1);

  // zero taps means one, too many means all of them
  always_comb begin
    priority if (tap_count == '0) begin
      ntaps_next = fcf_pkg::TAPN_W'(1);
    end else if (32'(tap_count) > fcf_pkg::MAX_TAPS) begin
      ntaps_next = fcf_pkg::TAPN_W'(fcf_pkg::MAX_TAPS);
    end else begin
      ntaps_next = fcf_pkg::TAPN_W'(tap_count);
    end
  end

  assign issue         = (state == S_RUN) && (k < ntaps);
  assign rd_coef_addr  = k[fcf_pkg::TAP_BITS-1:0];
  assign rd_delay_addr = head - k[fcf_pkg::TAP_BITS-1:0];

  assign d_op = d_ok ? d_rd : '0;
  assign c_op = c_ok ? c_rd : '0;

  // round half up, then clamp to the sample range
  assign rnd    = acc + (fcf_pkg::ACC_W'(1) << (fcf_pkg::FRAC_BITS - 1));
  assign q      = rnd >>> fcf_pkg::FRAC_BITS;
  assign sat_hi = !q[fcf_pkg::ACC_W-1] && (|q[fcf_pkg::ACC_W-2:fcf_pkg::SAMPLE_BITS-1]);
  assign sat_lo = q[fcf_pkg::ACC_W-1] && !(&q[fcf_pkg::ACC_W-2:fcf_pkg::SAMPLE_BITS-1]);

  always_comb begin
    res_next.saturated = sat_hi || sat_lo;
    priority if (sat_hi) begin
      res_next.out_sample = {1'b0, {(fcf_pkg::SAMPLE_BITS-1){1'b1}}};
    end else if (sat_lo) begin
      res_next.out_sample = {1'b1, {(fcf_pkg::SAMPLE_BITS-1){1'b0}}};
    end else begin
      res_next.out_sample = q[fcf_pkg::SAMPLE_BITS-1:0];
    end
  end

  // config register
  always_ff @(posedge clk) begin
    if (rst) begin
      tap_count <= fcf_pkg::TAP_COUNT_RESET;
    end else if (cfg_write) begin
      tap_count <= pwdata[fcf_pkg::TAP_COUNT_W-1:0];
    end
  end

  // memories: one write and one registered read each
  always_ff @(posedge clk) begin
    if (load_accept && (32'(req_data.coef_index) < fcf_pkg::MAX_TAPS)) begin
      coef_mem[coef_addr] <= req_data.coef_value;
    end
    if (sample_accept) begin
      delay_mem[head_next] <= req_data.sample;
    end
    if (issue) begin
      c_rd <= coef_mem[rd_coef_addr];
      d_rd <= delay_mem[rd_delay_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      coef_valid <= '0;
      head       <= '0;
      fill       <= '0;
    end else begin
      if (load_accept && (32'(req_data.coef_index) < fcf_pkg::MAX_TAPS)) begin
        coef_valid[coef_addr] <= 1'b1;
      end
      if (sample_accept) begin
        head <= head_next;
        if (32'(fill) < fcf_pkg::MAX_TAPS) begin
          fill <= fill + fcf_pkg::TAPN_W'(1);
        end
      end
    end
  end

  // sequencer, mac pipeline and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      if (res_valid && !res_stall && (state != S_DONE)) begin
        res_valid <= 1'b0;
      end

      s1_valid <= issue;
      if (issue) begin
        c_ok <= coef_valid[rd_coef_addr];
        d_ok <= (k < fill);
        k    <= k + fcf_pkg::TAPN_W'(1);
      end

      s2_valid <= s1_valid;
      if (s1_valid) begin
        prod <= d_op * c_op;
      end

      if (s2_valid) begin
        acc <= acc + {{(fcf_pkg::ACC_W-fcf_pkg::PROD_W){prod[fcf_pkg::PROD_W-1]}}, prod};
      end

      unique case (state)
        S_IDLE: begin
          if (sample_accept) begin
            state <= S_RUN;
            ntaps <= ntaps_next;
            k     <= '0;
            acc   <= '0;
          end
        end
        S_RUN: begin
          if ((k == ntaps) && !s1_valid && !s2_valid) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (!res_valid || !res_stall) begin
            res_valid <= 1'b1;
            res_data  <= res_next;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_sample_starts_run: assert property (@(posedge clk) disable iff (rst)
    sample_accept |=> (state == S_RUN))
    else $error("sample request did not start the tap sequence");

  a_result_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(res_valid) |-> ($past(state) == S_DONE))
    else $error("result appeared outside the done state");

  a_issue_bounded: assert property (@(posedge clk) disable iff (rst)
    (state == S_RUN) |-> (k <= ntaps))
    else $error("tap counter ran past the tap count");

  a_ntaps_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_RUN) |-> ((ntaps != '0) && (32'(ntaps) <= fcf_pkg::MAX_TAPS)))
    else $error("active tap count out of range");

  a_pipe_empty_on_done: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE) |-> (!s1_valid && !s2_valid && (k == ntaps)))
    else $error("done state reached with taps still in flight");

endmodule

/* tb/tb_top.sv */
// tb_top: self-checking bench for fir_convolution_filter_unit
// drives load and sample requests, predicts each filtered sample, checks every result
// depends on fcf_pkg and the filter unit rtl
module tb_top;

  localparam int CYCLE_LIMIT = 2_000_000;
  localparam int HOLD_LEN    = 1500;
  localparam int PHASE_ITEMS = 87;
  localparam int PACE_NONE   = 0;
  localparam int PACE_FULL   = 1;
  localparam int PACE_LIGHT  = 2;

  typedef struct {
    fcf_pkg::req_t req;
    int            gap;
    bit            drain;
  } pend_t;

  logic                           clk = 1'b0;
  logic                           rst = 1'b1;
  logic                           req_valid = 1'b0;
  logic                           req_stall;
  fcf_pkg::req_t                  req_data = '0;
  logic                           res_valid;
  logic                           res_stall = 1'b0;
  fcf_pkg::res_t                  res_data;
  logic                           psel = 1'b0;
  logic                           penable = 1'b0;
  logic                           pwrite = 1'b0;
  logic [fcf_pkg::APB_ADDR_W-1:0] paddr = '0;
  logic [fcf_pkg::APB_DATA_W-1:0] pwdata = '0;
  logic [fcf_pkg::APB_DATA_W-1:0] prdata;
  logic                           pready;

  // predictor state
  logic signed [fcf_pkg::SAMPLE_BITS-1:0] coef_taps [fcf_pkg::MAX_TAPS];
  logic signed [fcf_pkg::SAMPLE_BITS-1:0] sample_hist [fcf_pkg::MAX_TAPS];
  logic [fcf_pkg::TAP_COUNT_W-1:0]        taps_cfg = fcf_pkg::TAP_COUNT_RESET;

  pend_t         request_q [$];
  fcf_pkg::res_t filtered_q [$];

  int pace = PACE_NONE;
  int err_count = 0;
  int res_seen = 0;
  int cycle_cnt = 0;
  int tx_wait = 0;
  int rx_gap = 0;
  int rx_cnt = 0;
  int hold_asks = 0;
  int hold_seen = 0;
  int hold_left = 0;

  fir_convolution_filter_unit u_top (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req_data (req_data),
    .res_valid(res_valid),
    .res_stall(res_stall),
    .res_data (res_data),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always #10 clk = ~clk;

  initial begin
    foreach (coef_taps[k]) begin
      coef_taps[k] = '0;
      sample_hist[k] = '0;
    end
  end

  function automatic int active_taps();
    if (taps_cfg == 0) return 1;
    if (taps_cfg > fcf_pkg::MAX_TAPS) return fcf_pkg::MAX_TAPS;
    return int'(taps_cfg);
  endfunction

  function automatic int idle_draw();
    case (pace)
      PACE_NONE: return 0;
      PACE_FULL: return $urandom_range(0, 19);
      default:   return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 19) : 0;
    endcase
  endfunction

  function automatic logic [fcf_pkg::SAMPLE_BITS-1:0] pick_value();
    case ($urandom_range(0, 3))
      0: return fcf_pkg::SAMPLE_BITS'($urandom);
      1: begin
        case ($urandom_range(0, 3))
          0:       return 16'h7FFF;
          1:       return 16'h8000;
          2:       return 16'h0000;
          default: return 16'hFFFF;
        endcase
      end
      default: return fcf_pkg::SAMPLE_BITS'($urandom_range(0, 4095) - 2048);
    endcase
  endfunction

  // store a loaded coefficient, or shift in the sample, full-precision dot product, round half up, clamp
  function automatic void fir_step(fcf_pkg::req_t r);
    longint        acc;
    longint        q;
    int            n;
    fcf_pkg::res_t e;
    if (r.req_type == fcf_pkg::REQ_LOAD) begin
      coef_taps[r.coef_index] = r.coef_value;
      return;
    end
    for (int k = fcf_pkg::MAX_TAPS - 1; k > 0; k--) sample_hist[k] = sample_hist[k-1];
    sample_hist[0] = r.sample;
    n = active_taps();
    acc = 0;
    for (int k = 0; k < n; k++) acc += longint'(sample_hist[k]) * longint'(coef_taps[k]);
    q = (acc + (longint'(1) << (fcf_pkg::FRAC_BITS - 1))) >>> fcf_pkg::FRAC_BITS;
    e.saturated = 1'b0;
    if (q > 32767) begin
      q = 32767;
      e.saturated = 1'b1;
    end
    if (q < -32768) begin
      q = -32768;
      e.saturated = 1'b1;
    end
    e.out_sample = q[fcf_pkg::SAMPLE_BITS-1:0];
    filtered_q = {filtered_q, e};
  endfunction

  function automatic void queue_request(fcf_pkg::req_type_t kind,
                                        logic [fcf_pkg::COEF_INDEX_W-1:0] idx,
                                        logic [fcf_pkg::SAMPLE_BITS-1:0] cval,
                                        logic [fcf_pkg::SAMPLE_BITS-1:0] sval, bit drain);
    pend_t p;
    p.req.req_type   = kind;
    p.req.coef_index = idx;
    p.req.coef_value = cval;
    p.req.sample     = sval;
    p.gap            = idle_draw();
    p.drain          = drain;
    request_q = {request_q, p};
  endfunction

  task automatic report_mismatch(string what, longint want, longint got);
    $display("mismatch at result %0d: %s expected %0d got %0d", res_seen, what, want, got);
    err_count++;
  endtask

  // request driver
  always @(posedge clk) begin
    if (!rst) begin
      if (req_valid && !req_stall) fir_step(req_data);
      if (!req_valid || !req_stall) begin
        if (request_q.size() != 0 && tx_wait < request_q[0].gap) begin
          tx_wait++;
          req_valid <= 1'b0;
        end else if (request_q.size() != 0 &&
                     !(request_q[0].drain && filtered_q.size() != 0)) begin
          req_data  <= request_q[0].req;
          req_valid <= 1'b1;
          void'(request_q.pop_front());
          tx_wait = 0;
        end else begin
          req_valid <= 1'b0;
        end
      end
    end
  end

  // long receiver hold-off
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
    end else if (hold_asks != hold_seen) begin
      hold_seen <= hold_asks;
      hold_left <= HOLD_LEN;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // result monitor and checker
  always @(posedge clk) begin
    fcf_pkg::res_t e;
    if (!rst) begin
      if (res_valid && !res_stall) begin
        if (filtered_q.size() == 0) begin
          report_mismatch("unrequested result, out_sample", 0,
                          longint'(res_data.out_sample));
        end else begin
          e = filtered_q.pop_front();
          if (res_data.out_sample !== e.out_sample)
            report_mismatch("out_sample", longint'(e.out_sample),
                            longint'(res_data.out_sample));
          if (res_data.saturated !== e.saturated)
            report_mismatch("saturated", longint'(e.saturated),
                            longint'(res_data.saturated));
        end
        res_seen++;
        rx_gap = idle_draw();
        rx_cnt = 0;
      end else if (res_valid && res_stall && rx_cnt < rx_gap) begin
        rx_cnt++;
      end
      res_stall <= (hold_left != 0) || (rx_cnt < rx_gap);
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic apb_write(logic [fcf_pkg::APB_DATA_W-1:0] data);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= fcf_pkg::APB_ADDR_W'(fcf_pkg::REG_TAP_COUNT * 4);
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic apb_read_check(logic [fcf_pkg::TAP_COUNT_W-1:0] want);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= fcf_pkg::APB_ADDR_W'(fcf_pkg::REG_TAP_COUNT * 4);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata[fcf_pkg::TAP_COUNT_W-1:0] !== want)
      report_mismatch("tap_count readback", longint'(want),
                      longint'(prdata[fcf_pkg::TAP_COUNT_W-1:0]));
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_taps(logic [fcf_pkg::TAP_COUNT_W-1:0] value);
    apb_write(fcf_pkg::APB_DATA_W'(value));
    taps_cfg = value;
    apb_read_check(value);
    @(negedge clk);
  endtask

  // waits at the falling edge so driver and monitor have settled
  task automatic wait_idle();
    do @(negedge clk);
    while (request_q.size() != 0 || req_valid || filtered_q.size() != 0);
    repeat (16) @(negedge clk);
  endtask

  initial begin
    int tap_plan [12];
    int tc;
    int eff;
    logic [fcf_pkg::COEF_INDEX_W-1:0] idx;
    tap_plan = '{3, 0, 256, -1, 511, 1, -1, 128, 257, -1, 255, 2};
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    apb_read_check(fcf_pkg::TAP_COUNT_RESET);
    @(negedge clk);

    // directed: coefficient and sample extremes at one tap
    pace = PACE_NONE;
    queue_request(fcf_pkg::REQ_SAMPLE, 8'($urandom), 16'($urandom), 16'h7FFF, 1'b0);
    queue_request(fcf_pkg::REQ_LOAD, 8'd0, 16'h7FFF, 16'($urandom), 1'b0);
    queue_request(fcf_pkg::REQ_SAMPLE, 8'($urandom), 16'($urandom), 16'h7FFF, 1'b0);
    queue_request(fcf_pkg::REQ_LOAD, 8'd0, 16'h8000, 16'($urandom), 1'b0);
    queue_request(fcf_pkg::REQ_SAMPLE, 8'($urandom), 16'($urandom), 16'h8000, 1'b0);
    queue_request(fcf_pkg::REQ_SAMPLE, 8'($urandom), 16'($urandom), 16'h7FFF, 1'b0);
    queue_request(fcf_pkg::REQ_SAMPLE, 8'($urandom), 16'($urandom), 16'h0001, 1'b0);
    queue_request(fcf_pkg::REQ_SAMPLE, 8'($urandom), 16'($urandom), 16'hFFFF, 1'b0);
    queue_request(fcf_pkg::REQ_LOAD, 8'd255, 16'h7FFF, 16'($urandom), 1'b0);
    queue_request(fcf_pkg::REQ_LOAD, 8'd1, 16'h0001, 16'($urandom), 1'b0);
    queue_request(fcf_pkg::REQ_LOAD, 8'd0, 16'h4000, 16'($urandom), 1'b0);
    queue_request(fcf_pkg::REQ_SAMPLE, 8'($urandom), 16'($urandom), 16'h0000, 1'b0);
    queue_request(fcf_pkg::REQ_SAMPLE, 8'($urandom), 16'($urandom), 16'h0001, 1'b0);
    queue_request(fcf_pkg::REQ_SAMPLE, 8'($urandom), 16'($urandom), 16'hFFFF, 1'b0);
    wait_idle();

    for (int ph = 0; ph < 12; ph++) begin
      tc = (tap_plan[ph] < 0) ? $urandom_range(1, 40) : tap_plan[ph];
      set_taps(fcf_pkg::TAP_COUNT_W'(tc));
      eff = active_taps();
      case (ph % 3)
        0:       pace = PACE_FULL;
        1:       pace = PACE_NONE;
        default: pace = PACE_LIGHT;
      endcase
      // receiver holds off while the sender keeps offering back to back
      if (ph == 5) begin
        pace = PACE_NONE;
        hold_asks++;
      end
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if ($urandom_range(0, 99) < 35) begin
          idx = ($urandom_range(0, 1) == 0)
                  ? fcf_pkg::COEF_INDEX_W'($urandom_range(0, eff - 1))
                  : fcf_pkg::COEF_INDEX_W'($urandom);
          queue_request(fcf_pkg::REQ_LOAD, idx, pick_value(), 16'($urandom),
                        i == PHASE_ITEMS / 2);
        end else begin
          queue_request(fcf_pkg::REQ_SAMPLE, 8'($urandom), 16'($urandom), pick_value(),
                        i == PHASE_ITEMS / 2);
        end
      end
      wait_idle();
    end

    repeat (300) @(negedge clk);
    if (filtered_q.size() != 0)
      report_mismatch("results still owed", 0, longint'(filtered_q.size()));
    if (err_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
